### hw/rtl/vcf_pkg.sv
// Shared types, codes and reset values for the voice channel follow block.
// Used by every module under hw/rtl; depends on nothing else.

package vcf_pkg;

   // Request types carried by an input beat.
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_STOP  = 2'd2;

   // MAC PDU kinds; the unused codes fall through as "other".
   localparam logic [2:0] MK_PTT      = 3'd1;
   localparam logic [2:0] MK_ACTIVE   = 3'd2;
   localparam logic [2:0] MK_END_PTT  = 3'd3;
   localparam logic [2:0] MK_HANGTIME = 3'd4;
   localparam logic [2:0] MK_IDLE     = 3'd5;

   // Algorithm ids that mean clear voice.
   localparam logic [7:0] ALG_CLEAR_A = 8'hff;
   localparam logic [7:0] ALG_CLEAR_B = 8'h80;

   // Verdict codes of a result beat.
   localparam logic [3:0] V_STAY        = 4'd0;
   localparam logic [3:0] V_ENDED       = 4'd1;
   localparam logic [3:0] V_IDLE        = 4'd2;
   localparam logic [3:0] V_HANG        = 4'd3;
   localparam logic [3:0] V_NO_SYNC     = 4'd4;
   localparam logic [3:0] V_LOST        = 4'd5;
   localparam logic [3:0] V_QUIET       = 4'd6;
   localparam logic [3:0] V_ENCRYPTED   = 4'd7;
   localparam logic [3:0] V_OTHER_GROUP = 4'd8;

   // Phase codes as they appear on the result channel.
   localparam logic [2:0] PHASE_CODE_OFF     = 3'd0;
   localparam logic [2:0] PHASE_CODE_ACQUIRE = 3'd1;
   localparam logic [2:0] PHASE_CODE_CALL    = 3'd2;
   localparam logic [2:0] PHASE_CODE_ENDING  = 3'd3;
   localparam logic [2:0] PHASE_CODE_HANG    = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ACQUIRE_TIME   = 3'd0;
   localparam logic [2:0] CSR_LOST_TIME      = 3'd1;
   localparam logic [2:0] CSR_QUIET_TIME     = 3'd2;
   localparam logic [2:0] CSR_END_TIME       = 3'd3;
   localparam logic [2:0] CSR_HANG_TIME      = 3'd4;
   localparam logic [2:0] CSR_LEAVE_ON_CRYPT = 3'd5;

   // Configuration reset values in milliseconds.
   localparam logic [15:0] RST_ACQUIRE_TIME = 16'd1500;
   localparam logic [15:0] RST_LOST_TIME    = 16'd1000;
   localparam logic [15:0] RST_QUIET_TIME   = 16'd2000;
   localparam logic [15:0] RST_END_TIME     = 16'd500;
   localparam logic [15:0] RST_HANG_TIME    = 16'd2000;

   // Follow state machine, one-hot.
   typedef enum logic [4:0] {
      PH_OFF     = 5'b00001,
      PH_ACQUIRE = 5'b00010,
      PH_CALL    = 5'b00100,
      PH_ENDING  = 5'b01000,
      PH_HANG    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [15:0] acquire_time;
      logic [15:0] lost_time;
      logic [15:0] quiet_time;
      logic [15:0] end_time;
      logic [15:0] hang_time;
      logic        leave_on_crypt;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_ms;
      logic        status_valid;
      logic [31:0] burst_count;
      logic [31:0] voice_count;
      logic [31:0] control_count;
      logic        synchronized;
      logic [7:0]  algorithm_id;
      logic [15:0] talkgroup;
      logic [2:0]  mac_kind;
      logic [31:0] voice_symbol_pos;
      logic [31:0] mac_symbol_pos;
   } item_type;

   typedef struct packed {
      logic [3:0] verdict;
      logic [2:0] phase;
      logic       active;
   } result_type;

   // Maps the one-hot state onto the external phase code.
   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      begin
         unique case (ph)
            PH_ACQUIRE: code = PHASE_CODE_ACQUIRE;
            PH_CALL:    code = PHASE_CODE_CALL;
            PH_ENDING:  code = PHASE_CODE_ENDING;
            PH_HANG:    code = PHASE_CODE_HANG;
            default:    code = PHASE_CODE_OFF;
         endcase
         return code;
      end
   endfunction

endpackage

### hw/rtl/vcf_csr.sv
// Configuration registers of the voice channel follow block.
// Depends on vcf_pkg for the register indexes, reset values and cfg_type.

module vcf_csr import vcf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ACQUIRE_TIME:   cfg_in.acquire_time   = csr_wdata;
            CSR_LOST_TIME:      cfg_in.lost_time      = csr_wdata;
            CSR_QUIET_TIME:     cfg_in.quiet_time     = csr_wdata;
            CSR_END_TIME:       cfg_in.end_time       = csr_wdata;
            CSR_HANG_TIME:      cfg_in.hang_time      = csr_wdata;
            CSR_LEAVE_ON_CRYPT: cfg_in.leave_on_crypt = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.acquire_time   <= RST_ACQUIRE_TIME;
         cfg_ff.lost_time      <= RST_LOST_TIME;
         cfg_ff.quiet_time     <= RST_QUIET_TIME;
         cfg_ff.end_time       <= RST_END_TIME;
         cfg_ff.hang_time      <= RST_HANG_TIME;
         cfg_ff.leave_on_crypt <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/vcf_engine.sv
// Follow state and the combinational decision logic for one request beat.
// Depends on vcf_pkg; driven from the input register of the top level.

module vcf_engine import vcf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] group_ff, group_in;
   logic        ever_ff, ever_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] act_ff, act_in;
   logic [31:0] sync_ff, sync_in;
   logic [31:0] dl_ff, dl_in;
   logic [31:0] seen_b_ff, seen_b_in;
   logic [31:0] seen_v_ff, seen_v_in;
   logic [31:0] seen_c_ff, seen_c_in;

   logic        status;
   logic        db_nz, dv_nz, dc_nz;
   logic        sync_hit;
   logic        crypt_exit, group_exit;
   logic        voice_after, voice_before;
   logic [31:0] start_gap, sync_gap, act_gap, dl_gap;
   logic [16:0] acq_quiet;
   logic [3:0]  verdict;

   logic        idle_exit, act_set, dl_set, dl_use_hang;
   phase_type   phase_b;
   logic        ever_b;
   logic [15:0] dl_span;
   logic        nosync_fire, lost_fire, dl_fire, quiet_call, quiet_acq;

   // Counter growth is nonzero exactly when the count moved and is not zero:
   // a count that fell back grows by its new value.
   assign status = item.status_valid;
   assign db_nz  = (item.burst_count != seen_b_ff) && (item.burst_count != '0);
   assign dv_nz  = (item.voice_count != seen_v_ff) && (item.voice_count != '0);
   assign dc_nz  = (item.control_count != seen_c_ff) && (item.control_count != '0);
   assign sync_hit = status && db_nz && item.synchronized;

   // Leave tests that come straight from the beat.
   assign crypt_exit = status && cfg.leave_on_crypt &&
                       (item.algorithm_id != ALG_CLEAR_A) &&
                       (item.algorithm_id != ALG_CLEAR_B);
   assign group_exit = status && (group_ff != '0) && (item.talkgroup != '0) &&
                       (item.talkgroup != group_ff);
   assign voice_after  = item.voice_symbol_pos > item.mac_symbol_pos;
   assign voice_before = item.voice_symbol_pos < item.mac_symbol_pos;

   // Wrapping time differences against the stored stamps.
   assign start_gap = item.now_ms - start_ff;
   assign sync_gap  = item.now_ms - sync_ff;
   assign act_gap   = item.now_ms - act_ff;
   assign dl_gap    = item.now_ms - dl_ff;
   assign acq_quiet = {1'b0, cfg.acquire_time} + {1'b0, cfg.quiet_time};

   // Phase changes driven by a control PDU and by voice growth on a tick.
   always_comb begin
      phase_b     = phase_ff;
      idle_exit   = 1'b0;
      act_set     = 1'b0;
      dl_set      = 1'b0;
      dl_use_hang = 1'b0;
      if (status && dc_nz) begin
         priority if (item.mac_kind == MK_PTT || item.mac_kind == MK_ACTIVE) begin
            phase_b = PH_CALL;
            act_set = 1'b1;
         end else if (item.mac_kind == MK_END_PTT) begin
            if (phase_ff != PH_ENDING && phase_ff != PH_HANG) begin
               phase_b = PH_ENDING;
               dl_set  = 1'b1;
            end
         end else if (item.mac_kind == MK_HANGTIME) begin
            if (phase_ff != PH_HANG) begin
               phase_b     = PH_HANG;
               dl_set      = 1'b1;
               dl_use_hang = 1'b1;
            end
         end else if (item.mac_kind == MK_IDLE) begin
            idle_exit = !dv_nz || voice_before;
         end else begin
            phase_b = phase_ff;
         end
      end
      if (status && dv_nz && (item.control_count != '0) && (!dc_nz || voice_after)) begin
         phase_b = PH_CALL;
         act_set = 1'b1;
      end
   end

   // Timer tests; a stamp refreshed on this beat reads as zero elapsed time.
   assign ever_b      = ever_ff || sync_hit;
   assign dl_span     = dl_use_hang ? cfg.hang_time : cfg.end_time;
   assign nosync_fire = start_gap >= {16'b0, cfg.acquire_time};
   assign lost_fire   = sync_hit ? (cfg.lost_time == '0) :
                                   (sync_gap >= {16'b0, cfg.lost_time});
   assign dl_fire     = dl_set ? (dl_span == '0) : !dl_gap[31];
   assign quiet_call  = act_set ? (cfg.quiet_time == '0) :
                                  (act_gap >= {16'b0, cfg.quiet_time});
   assign quiet_acq   = act_set ? (acq_quiet == '0) :
                                  (act_gap >= {15'b0, acq_quiet});

   // Next state and verdict for the beat in the input register.
   always_comb begin
      phase_in  = phase_ff;
      group_in  = group_ff;
      ever_in   = ever_ff;
      start_in  = start_ff;
      act_in    = act_ff;
      sync_in   = sync_ff;
      dl_in     = dl_ff;
      seen_b_in = seen_b_ff;
      seen_v_in = seen_v_ff;
      seen_c_in = seen_c_ff;
      verdict   = V_STAY;
      if (item.req_type == REQ_START) begin
         phase_in  = PH_ACQUIRE;
         group_in  = item.talkgroup;
         ever_in   = 1'b0;
         start_in  = item.now_ms;
         act_in    = item.now_ms;
         sync_in   = item.now_ms;
         dl_in     = '0;
         seen_b_in = '0;
         seen_v_in = '0;
         seen_c_in = '0;
      end else if (item.req_type == REQ_STOP) begin
         phase_in = PH_OFF;
      end else if (item.req_type == REQ_TICK && phase_ff != PH_OFF) begin
         if (status) begin
            seen_b_in = item.burst_count;
            seen_v_in = item.voice_count;
            seen_c_in = item.control_count;
         end
         if (sync_hit) begin
            ever_in = 1'b1;
            sync_in = item.now_ms;
         end
         priority if (crypt_exit) begin
            verdict = V_ENCRYPTED;
         end else if (group_exit) begin
            verdict = V_OTHER_GROUP;
         end else if (idle_exit) begin
            verdict = V_IDLE;
         end else begin
            phase_in = phase_b;
            if (act_set) begin
               act_in = item.now_ms;
            end
            if (dl_set) begin
               dl_in = item.now_ms + {16'b0, dl_span};
            end
            if (!ever_b) begin
               if (nosync_fire) begin
                  verdict = V_NO_SYNC;
               end
            end else if (lost_fire) begin
               verdict = V_LOST;
            end else begin
               unique case (phase_b)
                  PH_ENDING:  if (dl_fire) verdict = V_ENDED;
                  PH_HANG:    if (dl_fire) verdict = V_HANG;
                  PH_ACQUIRE: if (quiet_acq) verdict = V_QUIET;
                  PH_CALL:    if (quiet_call) verdict = V_QUIET;
                  default:    verdict = V_STAY;
               endcase
            end
         end
         if (verdict != V_STAY) begin
            phase_in = PH_OFF;
         end
      end
   end

   // State advances only when the beat moves on to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OFF;
         group_ff  <= '0;
         ever_ff   <= 1'b0;
         start_ff  <= '0;
         act_ff    <= '0;
         sync_ff   <= '0;
         dl_ff     <= '0;
         seen_b_ff <= '0;
         seen_v_ff <= '0;
         seen_c_ff <= '0;
      end else if (adv) begin
         phase_ff  <= phase_in;
         group_ff  <= group_in;
         ever_ff   <= ever_in;
         start_ff  <= start_in;
         act_ff    <= act_in;
         sync_ff   <= sync_in;
         dl_ff     <= dl_in;
         seen_b_ff <= seen_b_in;
         seen_v_ff <= seen_v_in;
         seen_c_ff <= seen_c_in;
      end
   end

   assign result.verdict = verdict;
   assign result.phase   = phase_code(phase_in);
   assign result.active  = (phase_in != PH_OFF);

   // A start beat always leaves the block acquiring.
   a_start_acquires: assert property (@(posedge clock) disable iff (reset)
      adv && item.req_type == REQ_START |=> phase_ff == PH_ACQUIRE)
      else $error("start beat did not enter acquire");

   // A tick while off changes nothing.
   a_off_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      adv && item.req_type == REQ_TICK && phase_ff == PH_OFF |=>
      phase_ff == PH_OFF && $stable(seen_b_ff) && $stable(seen_c_ff))
      else $error("tick while off changed state");

   // Any leave verdict switches the block off.
   a_leave_turns_off: assert property (@(posedge clock) disable iff (reset)
      adv && verdict != V_STAY |=> phase_ff == PH_OFF)
      else $error("leave verdict did not switch off");

   // Sync is first seen only together with a fresh sync stamp.
   a_sync_stamp: assert property (@(posedge clock) disable iff (reset)
      $rose(ever_ff) |-> sync_ff == $past(item.now_ms))
      else $error("sync stamp missing when sync first seen");

endmodule

### hw/rtl/voice_channel_follow_fsm.sv
// Top level of the voice channel follow block: input register, result register
// and handshakes. Depends on vcf_pkg, vcf_csr and vcf_engine.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_ready  req_type, req_now_ms, status and counters
//   rsp       out         rsp_valid / rsp_ready  rsp_verdict, rsp_phase, rsp_active
//   csr       in          csr_we                 csr_index, csr_wdata
//
// A request beat sits in the input register while the decision logic and follow
// state resolve it, then lands in the result register; one beat per cycle is
// sustained while the result side is not stalled.
// Reset is synchronous and clears the follow state and both register valids.
// A stalled result holds the input register; a new beat is still taken whenever
// the input register drains into the result register in the same cycle.

module voice_channel_follow_fsm import vcf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_now_ms,
   input  logic        req_status_valid,
   input  logic [31:0] req_burst_count,
   input  logic [31:0] req_voice_count,
   input  logic [31:0] req_control_count,
   input  logic        req_synchronized,
   input  logic [7:0]  req_algorithm_id,
   input  logic [15:0] req_talkgroup,
   input  logic [2:0]  req_mac_kind,
   input  logic [31:0] req_voice_symbol_pos,
   input  logic [31:0] req_mac_symbol_pos,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_verdict,
   output logic [2:0]  rsp_phase,
   output logic        rsp_active,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type result;
   result_type result_ff, result_in;
   logic       out_valid_ff, out_valid_in;
   logic       adv;
   logic       take;

   vcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vcf_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // The input beat moves on when the result register is free or draining.
   assign adv       = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || adv;
   assign take      = req_valid && req_ready;

   // Input register.
   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff && !adv;
      if (take) begin
         item_in.req_type         = req_type;
         item_in.now_ms           = req_now_ms;
         item_in.status_valid     = req_status_valid;
         item_in.burst_count      = req_burst_count;
         item_in.voice_count      = req_voice_count;
         item_in.control_count    = req_control_count;
         item_in.synchronized     = req_synchronized;
         item_in.algorithm_id     = req_algorithm_id;
         item_in.talkgroup        = req_talkgroup;
         item_in.mac_kind         = req_mac_kind;
         item_in.voice_symbol_pos = req_voice_symbol_pos;
         item_in.mac_symbol_pos   = req_mac_symbol_pos;
         in_valid_in              = 1'b1;
      end
   end

   // Result register.
   always_comb begin
      result_in    = result_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (adv) begin
         result_in    = result;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_verdict = result_ff.verdict;
   assign rsp_phase   = result_ff.phase;
   assign rsp_active  = result_ff.active;

   // A leave verdict is always reported together with the off phase.
   a_leave_reports_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != V_STAY |-> rsp_phase == PHASE_CODE_OFF && !rsp_active)
      else $error("leave verdict reported with a live phase");

endmodule
